[design/svd_pkg.sv]
// ----------------------------------------------------------------------------
// svd_pkg: shared types and constants of the soft-decision Viterbi decoder
// Holds default sizes, register indexes, reset values, the controller state
// type and the soft quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package svd_pkg;

  localparam int CONSTRAINT_LEN_DEF = 7;
  localparam int TRACE_DEPTH_DEF    = 35;
  localparam int METRIC_BITS_DEF    = 24;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W  = 8;
  localparam int SOFT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_POLY_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_STEP  = 2'd2;

  localparam logic [CFG_W-1:0] POLY_FIRST_RST  = 7'd121;
  localparam logic [CFG_W-1:0] POLY_SECOND_RST = 7'd91;
  localparam logic [CFG_W-1:0] QUANT_STEP_RST  = 7'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACS,
    ST_SEARCH,
    ST_TRACE,
    ST_EMIT
  } svd_state_t;

  // Three-bit soft value: 7 is a confident one, 0 a confident zero.
  function automatic logic [SOFT_W-1:0] quantize(input logic signed [SAMPLE_W-1:0] x,
                                                 input logic [CFG_W-1:0] d);
    logic signed [10:0] xs;
    logic signed [10:0] d1;
    logic signed [10:0] d2;
    logic signed [10:0] d3;
    logic [SOFT_W-1:0]  q;
    xs = {{3{x[SAMPLE_W-1]}}, x};
    d1 = {4'b0000, d};
    d2 = d1 <<< 1;
    d3 = d1 + d2;
    if (xs < -d3)      q = 3'd7;
    else if (xs < -d2) q = 3'd6;
    else if (xs < -d1) q = 3'd5;
    else if (xs < 0)   q = 3'd4;
    else if (xs < d1)  q = 3'd3;
    else if (xs < d2)  q = 3'd2;
    else if (xs < d3)  q = 3'd1;
    else               q = 3'd0;
    return q;
  endfunction

endpackage

`default_nettype wire

[design/svd_ram.sv]
// ----------------------------------------------------------------------------
// svd_ram: generic simple dual-port RAM
// One write port with a per-lane write mask, one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module svd_ram #(
  parameter int WIDTH = 384,
  parameter int DEPTH = 36,
  parameter int LANES = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [LANES-1:0]         wmask,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  localparam int LANE_W = WIDTH / LANES;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (we && wmask[l]) begin
        mem[waddr][l*LANE_W +: LANE_W] <= wdata[l*LANE_W +: LANE_W];
      end
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/svd_acs_cell.sv]
// ----------------------------------------------------------------------------
// svd_acs_cell: add-compare-select cell for one trellis state
// Holds the path metric of its state, scores both incoming branches and
// hands the winning predecessor to the survivor store.
// ----------------------------------------------------------------------------
`default_nettype none

module svd_acs_cell #(
  parameter int CONSTRAINT_LEN = svd_pkg::CONSTRAINT_LEN_DEF,
  parameter int METRIC_BITS    = svd_pkg::METRIC_BITS_DEF,
  parameter int STATE          = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        update,
  input  wire logic                        restart,
  input  wire logic [METRIC_BITS-1:0]      pm0_in,
  input  wire logic [METRIC_BITS-1:0]      pm1_in,
  input  wire logic [CONSTRAINT_LEN-1:0]   poly_a,
  input  wire logic [CONSTRAINT_LEN-1:0]   poly_b,
  input  wire logic [svd_pkg::SOFT_W-1:0]  q0,
  input  wire logic [svd_pkg::SOFT_W-1:0]  q1,
  input  wire logic                        tail,
  input  wire logic [CONSTRAINT_LEN-1:0]   limit,
  output logic      [METRIC_BITS-1:0]      pm,
  output logic      [CONSTRAINT_LEN-2:0]   surv,
  output logic                             surv_we
);

  localparam int M      = CONSTRAINT_LEN - 1;
  localparam int NUM_ST = 1 << M;
  localparam int BIT    = (STATE >> (M - 1)) & 1;
  localparam int J0     = (STATE * 2) % NUM_ST;
  localparam logic [M-1:0] PRED0 = M'(J0);
  localparam logic [M-1:0] PRED1 = M'(J0 + 1);
  localparam logic [METRIC_BITS-1:0] METRIC_MAX = {METRIC_BITS{1'b1}};

  logic [CONSTRAINT_LEN-1:0] reg0, reg1;
  logic [3:0]                bm0, bm1;
  logic [METRIC_BITS:0]      sum0_w, sum1_w;
  logic [METRIC_BITS-1:0]    sum0, sum1, best0;
  logic                      ok0, ok1, take0, take1;

  function automatic logic [3:0] score(input logic [CONSTRAINT_LEN-1:0] r,
                                       input logic [CONSTRAINT_LEN-1:0] pa,
                                       input logic [CONSTRAINT_LEN-1:0] pb,
                                       input logic [2:0] a, input logic [2:0] b);
    logic [2:0] ma, mb;
    ma = (^(r & pa)) ? 3'd7 - a : a;
    mb = (^(r & pb)) ? 3'd7 - b : b;
    return {1'b0, ma} + {1'b0, mb};
  endfunction

  always_comb begin
    reg0   = {1'(BIT), PRED0};
    reg1   = {1'(BIT), PRED1};
    bm0    = score(reg0, poly_a, poly_b, q0, q1);
    bm1    = score(reg1, poly_a, poly_b, q0, q1);
    sum0_w = {1'b0, pm0_in} + (METRIC_BITS+1)'(bm0);
    sum1_w = {1'b0, pm1_in} + (METRIC_BITS+1)'(bm1);
    sum0   = sum0_w[METRIC_BITS] ? METRIC_MAX : sum0_w[METRIC_BITS-1:0];
    sum1   = sum1_w[METRIC_BITS] ? METRIC_MAX : sum1_w[METRIC_BITS-1:0];
    // During the flush only input-zero branches from the shrinking low set count.
    ok0    = !tail || (BIT == 0 && {1'b0, PRED0} < limit);
    ok1    = !tail || (BIT == 0 && {1'b0, PRED1} < limit);
    take0  = ok0 && (sum0 < METRIC_MAX);
    best0  = take0 ? sum0 : METRIC_MAX;
    take1  = ok1 && (sum1 < best0);
    surv    = take1 ? PRED1 : PRED0;
    surv_we = take0 || take1;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pm <= (STATE == 0) ? '0 : METRIC_MAX;
    end else if (update) begin
      pm <= take1 ? sum1 : best0;
    end
  end

endmodule

`default_nettype wire

[design/soft_viterbi_decoder_rate_half_unit.sv]
// ----------------------------------------------------------------------------
// soft_viterbi_decoder_rate_half_unit: rate 1/2 soft-decision Viterbi decoder
// Quantizes sample pairs, updates all path metrics in a row of ACS cells,
// finds the best state and traces back through the survivor RAM.
// ----------------------------------------------------------------------------
// Each input transfer is accepted in the idle state, then followed by an
// add-compare-select update across all 2^(K-1) cells, a best-state scan over
// 2^(K-2) mirror pairs (up to 2^(K-1) states during the encoder flush), a
// traceback with one survivor RAM row read per cycle, and the decoded bits,
// one per cycle while the output is not stalled. The traceback is bound by
// the single read port of the survivor RAM. After reset a clearing pass
// zeroes every row of the survivor RAM before the first transfer.
`default_nettype none

module soft_viterbi_decoder_rate_half_unit #(
  parameter int CONSTRAINT_LEN = svd_pkg::CONSTRAINT_LEN_DEF,
  parameter int TRACE_DEPTH    = svd_pkg::TRACE_DEPTH_DEF,
  parameter int METRIC_BITS    = svd_pkg::METRIC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [svd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [svd_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [15:0]                     s_axis_tdata,  // sample_first, sample_second
  input  wire logic                            s_axis_tuser,  // tail_pair
  input  wire logic                            s_axis_tlast,  // block_end
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [7:0]                      m_axis_tdata,  // decoded_bit, zero fill
  output logic                                 m_axis_tlast   // last_bit
);

  localparam int M      = CONSTRAINT_LEN - 1;
  localparam int NUM_ST = 1 << M;
  localparam int HALF_ST = NUM_ST / 2;
  localparam int COLS   = TRACE_DEPTH + 1;
  localparam int ROW_W  = $clog2(COLS);
  localparam int SC_W   = $clog2(TRACE_DEPTH + 1);
  localparam int DB_W   = $clog2(TRACE_DEPTH);
  localparam int LIM_W  = M + 1;
  localparam int RAM_W  = NUM_ST * M;

  svd_pkg::svd_state_t state, state_next;

  logic [svd_pkg::CFG_W-1:0] poly_first, poly_second, quant_step;
  logic [15:0]               poly_first_x, poly_second_x;

  logic [svd_pkg::SOFT_W-1:0] q0, q1;
  logic                       tail, blk_end;
  logic [ROW_W-1:0]           ring_pointer, clr_row, rd_row;
  logic [SC_W-1:0]            step_count, tk, eidx, estop;
  logic [3:0]                 tail_index, ts;
  logic [LIM_W-1:0]           limit;
  logic [M-1:0]               sidx, best_h, hh, trace_st, next_st;
  logic [METRIC_BITS-1:0]     best_x, xx, pa, pb;
  logic                       take, search_last;
  logic [TRACE_DEPTH-1:0]     dec_bits;

  logic [METRIC_BITS-1:0] pm_all [NUM_ST];
  logic [RAM_W-1:0]       surv_data, ram_wdata, rd_data;
  logic [NUM_ST-1:0]      surv_mask, ram_mask;
  logic [ROW_W-1:0]       ram_waddr;
  logic                   ram_we;

  logic accept, acs_update, restart, out_free, out_load, emit_more;

  assign poly_first_x  = {9'd0, poly_first};
  assign poly_second_x = {9'd0, poly_second};

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_first  <= svd_pkg::POLY_FIRST_RST;
      poly_second <= svd_pkg::POLY_SECOND_RST;
      quant_step  <= svd_pkg::QUANT_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        svd_pkg::REG_POLY_FIRST:  poly_first  <= cfg_data;
        svd_pkg::REG_POLY_SECOND: poly_second <= cfg_data;
        svd_pkg::REG_QUANT_STEP:  quant_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ACS cells, wired as the shift-register trellis butterfly.
  for (genvar s = 0; s < NUM_ST; s++) begin : g_cell
    localparam int J0 = (s * 2) % NUM_ST;
    svd_acs_cell #(
      .CONSTRAINT_LEN(CONSTRAINT_LEN),
      .METRIC_BITS(METRIC_BITS),
      .STATE(s)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .update(acs_update),
      .restart(restart),
      .pm0_in(pm_all[J0]),
      .pm1_in(pm_all[J0 + 1]),
      .poly_a(poly_first_x[CONSTRAINT_LEN-1:0]),
      .poly_b(poly_second_x[CONSTRAINT_LEN-1:0]),
      .q0(q0),
      .q1(q1),
      .tail(tail),
      .limit(limit),
      .pm(pm_all[s]),
      .surv(surv_data[s*M +: M]),
      .surv_we(surv_mask[s])
    );
  end

  svd_ram #(.WIDTH(RAM_W), .DEPTH(COLS), .LANES(NUM_ST)) u_surv (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .wmask(ram_mask),
    .raddr(rd_row),
    .rdata(rd_data)
  );

  // Best-state scan. Normal items compare state j with its mirror state.
  always_comb begin
    pa = pm_all[sidx];
    pb = pm_all[~sidx];
    if (tail) begin
      xx = pa;
      hh = sidx;
      search_last = ({1'b0, sidx} == limit - LIM_W'(1));
    end else begin
      if (pa < pb) begin
        xx = pa;
        hh = sidx;
      end else begin
        xx = pb;
        hh = ~sidx;
      end
      search_last = (sidx == M'(HALF_ST - 1));
    end
    take = (sidx == '0) || (xx < best_x);
  end

  always_comb begin
    next_st = rd_data[trace_st*M +: M];
    ts      = (tail_index > 4'(M)) ? 4'(M) : tail_index;
    out_free  = !m_axis_tvalid || m_axis_tready;
    emit_more = eidx < estop;
  end

  always_comb begin
    state_next = state;
    case (state)
      svd_pkg::ST_CLEAR:  if (clr_row == ROW_W'(COLS - 1)) state_next = svd_pkg::ST_IDLE;
      svd_pkg::ST_IDLE:   if (s_axis_tvalid) state_next = svd_pkg::ST_ACS;
      svd_pkg::ST_ACS:    state_next = svd_pkg::ST_SEARCH;
      svd_pkg::ST_SEARCH: if (search_last) state_next = svd_pkg::ST_TRACE;
      svd_pkg::ST_TRACE:  if (tk == SC_W'(TRACE_DEPTH)) state_next = svd_pkg::ST_EMIT;
      svd_pkg::ST_EMIT:   if (!emit_more) state_next = svd_pkg::ST_IDLE;
      default:            state_next = svd_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    acs_update    = 1'b0;
    restart       = 1'b0;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ring_pointer;
    ram_wdata     = surv_data;
    ram_mask      = surv_mask;
    case (state)
      svd_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_row;
        ram_wdata = '0;
        ram_mask  = '1;
      end
      svd_pkg::ST_IDLE: s_axis_tready = 1'b1;
      svd_pkg::ST_ACS: begin
        acs_update = 1'b1;
        ram_we     = 1'b1;
      end
      svd_pkg::ST_EMIT: begin
        out_load = emit_more && out_free;
        restart  = !emit_more && blk_end;
      end
      default: ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= svd_pkg::ST_CLEAR;
      clr_row      <= '0;
      ring_pointer <= '0;
      step_count   <= '0;
      tail_index   <= '0;
    end else begin
      state <= state_next;
      if (state == svd_pkg::ST_CLEAR) clr_row <= clr_row + ROW_W'(1);
      if (accept) begin
        ring_pointer <= (ring_pointer == ROW_W'(COLS - 1)) ? '0 : ring_pointer + ROW_W'(1);
      end
      if (acs_update) begin
        if (step_count < SC_W'(TRACE_DEPTH)) step_count <= step_count + SC_W'(1);
        if (!tail) tail_index <= '0;
        else if (tail_index != 4'hF) tail_index <= tail_index + 4'd1;
      end
      if (restart) begin
        ring_pointer <= '0;
        step_count   <= '0;
        tail_index   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q0      <= svd_pkg::quantize(s_axis_tdata[7:0], quant_step);
      q1      <= svd_pkg::quantize(s_axis_tdata[15:8], quant_step);
      tail    <= s_axis_tuser;
      blk_end <= s_axis_tlast;
      limit   <= s_axis_tuser ? (LIM_W'(NUM_ST) >> ts) : LIM_W'(NUM_ST);
    end
    if (acs_update) sidx <= '0;
    if (state == svd_pkg::ST_SEARCH) begin
      sidx <= sidx + M'(1);
      if (take) begin
        best_x <= xx;
        best_h <= hh;
      end
      if (search_last) begin
        trace_st <= take ? hh : best_h;
        rd_row   <= ring_pointer;
        tk       <= '0;
      end
    end
    // One survivor row is read per cycle, walking back from the newest column.
    if (state == svd_pkg::ST_TRACE) begin
      rd_row <= (rd_row == '0) ? ROW_W'(COLS - 1) : rd_row - ROW_W'(1);
      tk     <= tk + SC_W'(1);
      if (tk != '0) begin
        trace_st <= next_st;
        dec_bits[DB_W'(SC_W'(TRACE_DEPTH) - tk)] <=
          (trace_st[M-2:0] == next_st[M-1:1]) ? trace_st[M-1] : 1'b0;
      end
      if (tk == SC_W'(TRACE_DEPTH)) begin
        if (blk_end) begin
          eidx  <= SC_W'(TRACE_DEPTH) - step_count;
          estop <= SC_W'(TRACE_DEPTH - M);
        end else begin
          eidx  <= '0;
          estop <= (step_count >= SC_W'(TRACE_DEPTH)) ? SC_W'(1) : '0;
        end
      end
    end
    if (out_load) eidx <= eidx + SC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {7'd0, dec_bits[eidx[DB_W-1:0]]};
      m_axis_tlast <= blk_end && (eidx + SC_W'(1) == estop);
    end
  end

endmodule

`default_nettype wire
